FILE: sv/first_fit_block_allocator_top_defines.svh
// Assertion macros for the first-fit allocator checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FFBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/ffba_pkg.sv
// Shared types, codes and microcode ROM of the first-fit block allocator.
// No dependencies.
package ffba_pkg;

    localparam int ARENA_WORDS_DEF = 4096;
    localparam int WORD_BITS_DEF   = 32;
    localparam int LEN_BITS        = 12;
    localparam int STATUS_BITS     = 2;
    localparam int S_TDATA_BITS    = 24;
    localparam int M_TDATA_BITS    = 16;

    typedef logic [STATUS_BITS-1:0] status_t;
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_OOM  = 2'd1;
    localparam status_t ST_ZERO = 2'd2;

    localparam int STEP_BITS = 5;
    typedef logic [STEP_BITS-1:0] step_t;

    localparam step_t S_CLR       = 5'd0;
    localparam step_t S_IDLE      = 5'd1;
    localparam step_t S_DISPATCH  = 5'd2;
    localparam step_t S_ZCHK      = 5'd3;
    localparam step_t S_START     = 5'd4;
    localparam step_t S_WALK      = 5'd5;
    localparam step_t S_LOAD      = 5'd6;
    localparam step_t S_END       = 5'd7;
    localparam step_t S_FIT       = 5'd8;
    localparam step_t S_SPLITCHK  = 5'd9;
    localparam step_t S_SPLIT_HDR = 5'd10;
    localparam step_t S_SPLIT_REM = 5'd11;
    localparam step_t S_MARK      = 5'd12;
    localparam step_t S_ADV       = 5'd13;
    localparam step_t S_STEP      = 5'd14;
    localparam step_t S_APP       = 5'd15;
    localparam step_t S_APP_HDR   = 5'd16;
    localparam step_t S_APP_END   = 5'd17;
    localparam step_t S_RES_OK    = 5'd18;
    localparam step_t S_RES_OOM   = 5'd19;
    localparam step_t S_RES_ZERO  = 5'd20;
    localparam step_t S_FREE      = 5'd21;
    localparam step_t S_FREE_RD   = 5'd22;
    localparam step_t S_FREE_LD   = 5'd23;
    localparam step_t S_FREE_WR   = 5'd24;
    localparam step_t S_RES_FREE  = 5'd25;

    typedef logic [1:0] rdsel_t;
    localparam rdsel_t RD_NONE = 2'd0;
    localparam rdsel_t RD_POS  = 2'd1;
    localparam rdsel_t RD_FREE = 2'd2;

    typedef logic [1:0] wasel_t;
    localparam wasel_t WA_POS   = 2'd0;
    localparam wasel_t WA_SPLIT = 2'd1;
    localparam wasel_t WA_FREE  = 2'd2;

    typedef logic [2:0] wdsel_t;
    localparam wdsel_t WD_ZERO    = 3'd0;
    localparam wdsel_t WD_NEWHDR  = 3'd1;
    localparam wdsel_t WD_REM     = 3'd2;
    localparam wdsel_t WD_MARK    = 3'd3;
    localparam wdsel_t WD_CLRUSED = 3'd4;

    typedef logic [1:0] posop_t;
    localparam posop_t POS_HOLD = 2'd0;
    localparam posop_t POS_CLR  = 2'd1;
    localparam posop_t POS_INC  = 2'd2;
    localparam posop_t POS_ADV  = 2'd3;

    typedef logic [1:0] res_t;
    localparam res_t RES_OK   = 2'd0;
    localparam res_t RES_OOM  = 2'd1;
    localparam res_t RES_ZERO = 2'd2;
    localparam res_t RES_FREE = 2'd3;

    typedef logic [3:0] cond_t;
    localparam cond_t C_NONE     = 4'd0;
    localparam cond_t C_ALWAYS   = 4'd1;
    localparam cond_t C_NOT_LAST = 4'd2;
    localparam cond_t C_FREE     = 4'd3;
    localparam cond_t C_ZERO     = 4'd4;
    localparam cond_t C_END      = 4'd5;
    localparam cond_t C_NOFIT    = 4'd6;
    localparam cond_t C_NOSPLIT  = 4'd7;
    localparam cond_t C_NEXT_OFF = 4'd8;
    localparam cond_t C_APP_OOM  = 4'd9;
    localparam cond_t C_BADFREE  = 4'd10;

    typedef struct packed {
        logic   wait_in;
        logic   wait_out;
        rdsel_t rd;
        logic   wr;
        wasel_t wa;
        wdsel_t wd;
        posop_t pos;
        logic   ld_hdr;
        logic   emit;
        res_t   res;
        cond_t  cond;
        step_t  target;
    } uc_word_t;

    typedef struct packed {
        logic not_last;
        logic free_req;
        logic zero_len;
        logic at_end;
        logic no_fit;
        logic no_split;
        logic next_off;
        logic app_oom;
        logic bad_free;
        logic out_free;
    } dp_flags_t;

    function automatic uc_word_t mk(input logic wi, input logic wo, input rdsel_t rd,
                                    input logic wr, input wasel_t wa, input wdsel_t wd,
                                    input posop_t pos, input logic ld, input logic emit,
                                    input res_t res, input cond_t cond, input step_t tgt);
        uc_word_t w;
        w.wait_in  = wi;
        w.wait_out = wo;
        w.rd       = rd;
        w.wr       = wr;
        w.wa       = wa;
        w.wd       = wd;
        w.pos      = pos;
        w.ld_hdr   = ld;
        w.emit     = emit;
        w.res      = res;
        w.cond     = cond;
        w.target   = tgt;
        return w;
    endfunction

    // microcode ROM
    function automatic uc_word_t ucode(input step_t step);
        uc_word_t w;
        unique case (step)
            S_CLR:       w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_POS, WD_ZERO, POS_INC,
                                1'b0, 1'b0, RES_OK, C_NOT_LAST, S_CLR);
            S_IDLE:      w = mk(1'b1, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_DISPATCH:  w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_FREE, S_FREE);
            S_ZCHK:      w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_ZERO, S_RES_ZERO);
            S_START:     w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_CLR,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_WALK:      w = mk(1'b0, 1'b0, RD_POS, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_LOAD:      w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b1, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_END:       w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_END, S_APP);
            S_FIT:       w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NOFIT, S_ADV);
            S_SPLITCHK:  w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NOSPLIT, S_MARK);
            S_SPLIT_HDR: w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_POS, WD_NEWHDR, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_SPLIT_REM: w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_SPLIT, WD_REM, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_ALWAYS, S_RES_OK);
            S_MARK:      w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_POS, WD_MARK, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_ALWAYS, S_RES_OK);
            S_ADV:       w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NEXT_OFF, S_RES_OOM);
            S_STEP:      w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_ADV,
                                1'b0, 1'b0, RES_OK, C_ALWAYS, S_WALK);
            S_APP:       w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_APP_OOM, S_RES_OOM);
            S_APP_HDR:   w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_POS, WD_NEWHDR, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_APP_END:   w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_SPLIT, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_RES_OK:    w = mk(1'b0, 1'b1, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b1, RES_OK, C_ALWAYS, S_IDLE);
            S_RES_OOM:   w = mk(1'b0, 1'b1, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b1, RES_OOM, C_ALWAYS, S_IDLE);
            S_RES_ZERO:  w = mk(1'b0, 1'b1, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b1, RES_ZERO, C_ALWAYS, S_IDLE);
            S_FREE:      w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_BADFREE, S_RES_FREE);
            S_FREE_RD:   w = mk(1'b0, 1'b0, RD_FREE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_FREE_LD:   w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b1, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_FREE_WR:   w = mk(1'b0, 1'b0, RD_NONE, 1'b1, WA_FREE, WD_CLRUSED, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_NONE, S_IDLE);
            S_RES_FREE:  w = mk(1'b0, 1'b1, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b1, RES_FREE, C_ALWAYS, S_IDLE);
            default:     w = mk(1'b0, 1'b0, RD_NONE, 1'b0, WA_POS, WD_ZERO, POS_HOLD,
                                1'b0, 1'b0, RES_OK, C_ALWAYS, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/ffba_mem.sv
// Header arena: one write port, one registered read port.
// No dependencies.
module ffba_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] arena_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            arena_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= arena_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/ffba_seq.sv
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// Depends on ffba_pkg.
module ffba_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  ffba_pkg::dp_flags_t  flags,
    output ffba_pkg::uc_word_t   cw,
    output logic                 go,
    output logic                 in_ready
);

    ffba_pkg::step_t upc_reg;
    ffba_pkg::step_t upc_next;
    logic            taken;

    assign cw       = ffba_pkg::ucode(upc_reg);
    assign in_ready = cw.wait_in;
    assign go       = (!cw.wait_in || in_valid) && (!cw.wait_out || flags.out_free);

    always_comb
    begin
        unique case (cw.cond)
            ffba_pkg::C_NONE:     taken = 1'b0;
            ffba_pkg::C_ALWAYS:   taken = 1'b1;
            ffba_pkg::C_NOT_LAST: taken = flags.not_last;
            ffba_pkg::C_FREE:     taken = flags.free_req;
            ffba_pkg::C_ZERO:     taken = flags.zero_len;
            ffba_pkg::C_END:      taken = flags.at_end;
            ffba_pkg::C_NOFIT:    taken = flags.no_fit;
            ffba_pkg::C_NOSPLIT:  taken = flags.no_split;
            ffba_pkg::C_NEXT_OFF: taken = flags.next_off;
            ffba_pkg::C_APP_OOM:  taken = flags.app_oom;
            ffba_pkg::C_BADFREE:  taken = flags.bad_free;
            default:              taken = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (go)
        begin
            upc_next = taken ? cw.target : upc_reg + ffba_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ffba_pkg::S_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: sv/ffba_dp.sv
// Datapath: request and header registers, address arithmetic, arena, result register.
// Depends on ffba_pkg and ffba_mem.
module ffba_dp #(
    parameter int ARENA_WORDS = ffba_pkg::ARENA_WORDS_DEF,
    parameter int WORD_BITS   = ffba_pkg::WORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ffba_pkg::uc_word_t                   cw,
    input  logic                                 go,
    input  logic                                 in_user,
    input  logic [ffba_pkg::S_TDATA_BITS-1:0]    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ffba_pkg::M_TDATA_BITS-1:0]    out_data,
    output ffba_pkg::dp_flags_t                  flags
);

    localparam int ADDR_BITS = $clog2(ARENA_WORDS);
    localparam int LB        = ffba_pkg::LEN_BITS;
    localparam int BLEN_BITS = WORD_BITS - 1;
    localparam int MAXB      = (BLEN_BITS > ADDR_BITS)
                               ? ((BLEN_BITS > LB) ? BLEN_BITS : LB)
                               : ((ADDR_BITS > LB) ? ADDR_BITS : LB);
    localparam int SW        = MAXB + 2;
    localparam int FW        = ((ADDR_BITS > LB) ? ADDR_BITS : LB) + 1;
    localparam int PAD_BITS  = ffba_pkg::M_TDATA_BITS - LB - ffba_pkg::STATUS_BITS;

    localparam logic [SW-1:0]        ARENA_S  = SW'(ARENA_WORDS);
    localparam logic [FW-1:0]        ARENA_F  = FW'(ARENA_WORDS);
    localparam logic [ADDR_BITS-1:0] LAST_POS = ADDR_BITS'(ARENA_WORDS - 1);

    logic                    type_reg;
    logic [LB-1:0]           len_reg;
    logic [LB-1:0]           baddr_reg;
    logic [ADDR_BITS-1:0]    pos_reg;
    logic [ADDR_BITS-1:0]    pos_next;
    logic [WORD_BITS-1:0]    hdr_reg;
    logic                    out_valid_reg;
    logic [LB-1:0]           out_addr_reg;
    ffba_pkg::status_t       out_status_reg;

    logic [SW-1:0]           pos_w;
    logic [SW-1:0]           blen_w;
    logic [SW-1:0]           len_w;
    logic [SW-1:0]           next_w;
    logic [SW-1:0]           split_w;
    logic [SW-1:0]           diff_w;
    logic [SW-1:0]           rem_w;
    logic [SW-1:0]           res_w;
    logic [FW-1:0]           free_w;
    logic                    split_in;

    logic                    mem_we;
    logic [ADDR_BITS-1:0]    mem_waddr;
    logic [WORD_BITS-1:0]    mem_wdata;
    logic                    mem_re;
    logic [ADDR_BITS-1:0]    mem_raddr;
    logic [WORD_BITS-1:0]    mem_rdata;
    logic                    in_xfer;

    assign in_xfer = go && cw.wait_in;

    assign pos_w   = SW'(pos_reg);
    assign blen_w  = SW'(hdr_reg[WORD_BITS-1:1]);
    assign len_w   = SW'(len_reg);
    assign next_w  = pos_w + blen_w + SW'(1);
    assign split_w = pos_w + len_w + SW'(1);
    assign diff_w  = blen_w - len_w;
    assign rem_w   = diff_w - SW'(1);
    assign res_w   = pos_w + SW'(1);
    assign free_w  = FW'(baddr_reg) - FW'(1);
    assign split_in = split_w < ARENA_S;

    assign flags.not_last = pos_reg != LAST_POS;
    assign flags.free_req = type_reg;
    assign flags.zero_len = len_reg == '0;
    assign flags.at_end   = blen_w == '0;
    assign flags.no_fit   = hdr_reg[0] || (blen_w < len_w);
    assign flags.no_split = diff_w <= SW'(2);
    assign flags.next_off = next_w >= ARENA_S;
    assign flags.app_oom  = !split_in;
    assign flags.bad_free = (baddr_reg == '0) || (free_w >= ARENA_F);
    assign flags.out_free = !out_valid_reg || out_ready;

    // write port
    always_comb
    begin
        unique case (cw.wa)
            ffba_pkg::WA_POS:   mem_waddr = pos_reg;
            ffba_pkg::WA_SPLIT: mem_waddr = split_w[ADDR_BITS-1:0];
            ffba_pkg::WA_FREE:  mem_waddr = free_w[ADDR_BITS-1:0];
            default:            mem_waddr = pos_reg;
        endcase
        unique case (cw.wd)
            ffba_pkg::WD_ZERO:    mem_wdata = '0;
            ffba_pkg::WD_NEWHDR:  mem_wdata = WORD_BITS'({len_reg, 1'b1});
            ffba_pkg::WD_REM:     mem_wdata = {rem_w[WORD_BITS-2:0], 1'b0};
            ffba_pkg::WD_MARK:    mem_wdata = hdr_reg | WORD_BITS'(1);
            ffba_pkg::WD_CLRUSED: mem_wdata = {hdr_reg[WORD_BITS-1:1], 1'b0};
            default:              mem_wdata = '0;
        endcase
    end

    // remainder header past the arena is dropped
    assign mem_we    = go && cw.wr && ((cw.wa != ffba_pkg::WA_SPLIT) || split_in);
    assign mem_re    = go && (cw.rd != ffba_pkg::RD_NONE);
    assign mem_raddr = (cw.rd == ffba_pkg::RD_FREE) ? free_w[ADDR_BITS-1:0] : pos_reg;

    ffba_mem #(
        .DEPTH (ARENA_WORDS),
        .WIDTH (WORD_BITS)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        pos_next = pos_reg;
        if (go)
        begin
            unique case (cw.pos)
                ffba_pkg::POS_HOLD: pos_next = pos_reg;
                ffba_pkg::POS_CLR:  pos_next = '0;
                ffba_pkg::POS_INC:  pos_next = pos_reg + ADDR_BITS'(1);
                ffba_pkg::POS_ADV:  pos_next = next_w[ADDR_BITS-1:0];
                default:            pos_next = pos_reg;
            endcase
        end
    end

    // pos_reg doubles as the clearing-pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (go && cw.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            type_reg  <= in_user;
            len_reg   <= in_data[LB-1:0];
            baddr_reg <= in_data[2*LB-1:LB];
        end
        if (go && cw.ld_hdr)
        begin
            hdr_reg <= mem_rdata;
        end
        if (go && cw.emit)
        begin
            unique case (cw.res)
                ffba_pkg::RES_OK:
                begin
                    out_addr_reg   <= res_w[LB-1:0];
                    out_status_reg <= ffba_pkg::ST_OK;
                end
                ffba_pkg::RES_OOM:
                begin
                    out_addr_reg   <= '0;
                    out_status_reg <= ffba_pkg::ST_OOM;
                end
                ffba_pkg::RES_ZERO:
                begin
                    out_addr_reg   <= '0;
                    out_status_reg <= ffba_pkg::ST_ZERO;
                end
                default:
                begin
                    out_addr_reg   <= '0;
                    out_status_reg <= ffba_pkg::ST_OK;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{PAD_BITS{1'b0}}, out_status_reg, out_addr_reg};

endmodule

FILE: sv/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: sequencer plus datapath.
// Depends on ffba_pkg, ffba_seq, ffba_dp.
//
// channel   dir  tdata                                    tuser
// s_axis    in   [11:0] request_length, [23:12] block_addr [0] req_type (0 alloc, 1 free)
// m_axis    out  [11:0] result_address, [13:12] status    -
//
// After reset a clearing pass writes every arena word with s_axis_tready low.
// Alloc reads one arena header per block it visits, skipped headers included; a split adds a header write.
// Free reads and rewrites one header, skipped for address 0; a zero-length alloc touches no arena word.
// The result sits in an output register; the next request is taken while it waits.
// A stalled m_axis holds the sequencer only when its next result is ready.
module first_fit_block_allocator_top #(
    parameter int ARENA_WORDS = ffba_pkg::ARENA_WORDS_DEF,
    parameter int WORD_BITS   = ffba_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ffba_pkg::S_TDATA_BITS-1:0] s_axis_tdata,   // request_length, block_address
    input  logic                              s_axis_tuser,   // req_type
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ffba_pkg::M_TDATA_BITS-1:0] m_axis_tdata    // result_address, status, pad
);

    ffba_pkg::uc_word_t  cw;
    ffba_pkg::dp_flags_t flags;
    logic                go;

    ffba_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .flags    (flags),
        .cw       (cw),
        .go       (go),
        .in_ready (s_axis_tready)
    );

    ffba_dp #(
        .ARENA_WORDS (ARENA_WORDS),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .go        (go),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .flags     (flags)
    );

endmodule

FILE: sv/ffba_chk.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_top_defines.svh.
`include "first_fit_block_allocator_top_defines.svh"

module ffba_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [ffba_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    input logic                              s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [ffba_pkg::M_TDATA_BITS-1:0] m_axis_tdata
);

    logic [ffba_pkg::LEN_BITS-1:0] res_addr;
    ffba_pkg::status_t             res_status;

    assign res_addr   = m_axis_tdata[ffba_pkg::LEN_BITS-1:0];
    assign res_status = m_axis_tdata[ffba_pkg::LEN_BITS+ffba_pkg::STATUS_BITS-1:ffba_pkg::LEN_BITS];

    `FFBA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `FFBA_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while previous one in flight")
    `FFBA_ASSERT_IMP(a_addr_ok, m_axis_tvalid && (res_addr != '0), res_status == ffba_pkg::ST_OK, "address returned with failing status")
    `FFBA_ASSERT_IMP(a_status_code, m_axis_tvalid, (res_status == ffba_pkg::ST_OK) || (res_status == ffba_pkg::ST_OOM) || (res_status == ffba_pkg::ST_ZERO), "undefined status code")

endmodule

bind first_fit_block_allocator_top ffba_chk u_ffba_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
